/* rtl/core/hpg_pkg.sv */
// Shared constants and elaboration-time helpers for the Halton point generator.
package hpg_pkg;

  localparam int INDEX_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int SAMPLE_INDEX_W    = 16;
  localparam int MAX_SAMPLES_W     = 17;
  localparam logic [MAX_SAMPLES_W-1:0] MAX_SAMPLES_RESET = 17'd64;

  // 3^k, used only on constants
  function automatic longint unsigned pow3(input int k);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

  // number of base-3 digits needed to cover an index of the given width
  function automatic int base3_digits(input int bits);
    longint unsigned p;
    int k;
    p = 64'd1;
    k = 0;
    while (p < (64'd1 << bits)) begin
      p = p * 64'd3;
      k = k + 1;
    end
    return k;
  endfunction

endpackage

/* rtl/core/halton_point_generator_core.sv */
// Halton point generator: base-2 and base-3 radical inverse of a sample index.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  sample_index
//   output    out        out_valid / out_stall in_range, coord_base2, coord_base3
//   config    in         cfg_valid / cfg_ready cfg_data (sample limit)
//
// In-range index: the digit loop takes one base-3 digit a cycle against a table of
// powers of 3. Out-of-range index: the loop is skipped. The next beat is taken once
// the result is loaded into the output register.
// Reset clears the sequencer, the output valid and sets the limit to 64.
// A result waiting on out_stall sits in the output register while the next beat runs.
module halton_point_generator_core #(
  parameter int INDEX_BITS    = hpg_pkg::INDEX_BITS_DEF,
  parameter int FRACTION_BITS = hpg_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hpg_pkg::SAMPLE_INDEX_W-1:0] sample_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               in_range,
  output logic [FRACTION_BITS-1:0]           coord_base2,
  output logic [FRACTION_BITS-1:0]           coord_base3,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hpg_pkg::MAX_SAMPLES_W-1:0]  cfg_data
);

  localparam int DIGITS = hpg_pkg::base3_digits(INDEX_BITS);
  localparam int CW     = $clog2(DIGITS);
  localparam int PAIRS  = (INDEX_BITS + 1) / 2;
  localparam int B2W    = 2 * PAIRS;
  localparam int TW     = FRACTION_BITS + 2;
  localparam logic [TW:0] RECIP =
    (TW+1)'(((64'd1 << (TW + 1)) + 64'd2) / 64'd3);
  localparam logic [CW-1:0] LAST_CNT  = CW'(DIGITS - 1);
  localparam logic [CW-1:0] B2_CUTOFF = CW'(DIGITS - PAIRS);

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t                           state;
  logic [CW-1:0]                    cnt;
  logic [INDEX_BITS-1:0]            rem;
  logic [B2W-1:0]                   n2;
  logic [FRACTION_BITS-1:0]         coord2;
  logic [FRACTION_BITS-1:0]         q;
  logic                             hit;
  logic [hpg_pkg::MAX_SAMPLES_W-1:0] max_samples;

  logic [INDEX_BITS-1:0]    pow_tab [DIGITS];
  logic [INDEX_BITS-1:0]    n_load;
  logic [INDEX_BITS-1:0]    p;
  logic [INDEX_BITS:0]      p2;
  logic [1:0]               digit;
  logic [INDEX_BITS-1:0]    rem_next;
  logic [TW-1:0]            t;
  logic [2*TW:0]            prod;
  logic [FRACTION_BITS-1:0] q_next;
  logic [FRACTION_BITS-1:0] coord2_next;
  logic [B2W-1:0]           n2_next;
  logic                     in_hit;
  logic                     out_free;
  logic                     out_load;

  for (genvar g = 0; g < DIGITS; g++) begin : g_pow
    assign pow_tab[g] = INDEX_BITS'(hpg_pkg::pow3(g));
  end

  if (INDEX_BITS >= hpg_pkg::SAMPLE_INDEX_W) begin : g_wide
    assign n_load = INDEX_BITS'(sample_index);
  end else begin : g_narrow
    assign n_load = sample_index[INDEX_BITS-1:0];
  end

  assign in_hit    = {1'b0, sample_index} < max_samples;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && ((state == FINISH) || (state == RUN && cnt == '0));
  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    p  = pow_tab[cnt];
    p2 = {p, 1'b0};
    if ({1'b0, rem} >= p2) begin
      digit = 2'd2;
    end else if (rem >= p) begin
      digit = 2'd1;
    end else begin
      digit = 2'd0;
    end
    case (digit)
      2'd2:    rem_next = rem - p2[INDEX_BITS-1:0];
      2'd1:    rem_next = rem - p;
      default: rem_next = rem;
    endcase
    // floor((digit * 2^F + q) / 3) by reciprocal multiply
    t      = {digit, q};
    prod   = (2*TW+1)'(t) * (2*TW+1)'(RECIP);
    q_next = prod[TW+1 +: FRACTION_BITS];
    if (cnt >= B2_CUTOFF) begin
      coord2_next = {n2[B2W-2], n2[B2W-1], coord2[FRACTION_BITS-1:2]};
      n2_next     = n2 << 2;
    end else begin
      coord2_next = coord2;
      n2_next     = n2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      max_samples <= hpg_pkg::MAX_SAMPLES_RESET;
    end else begin
      if (cfg_valid) begin
        max_samples <= cfg_data;
      end
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        IDLE: begin
          if (in_valid) begin
            hit    <= in_hit;
            rem    <= n_load;
            n2     <= B2W'(n_load);
            coord2 <= '0;
            q      <= '0;
            cnt    <= LAST_CNT;
            state  <= in_hit ? RUN : FINISH;
          end
        end
        RUN: begin
          rem    <= rem_next;
          q      <= q_next;
          coord2 <= coord2_next;
          n2     <= n2_next;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            if (out_free) begin
              in_range    <= hit;
              coord_base2 <= coord2_next;
              coord_base3 <= q_next;
              state       <= IDLE;
            end else begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (out_free) begin
            in_range    <= hit;
            coord_base2 <= coord2;
            coord_base3 <= q;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> coord_base2 == '0 && coord_base3 == '0)
    else $error("out-of-range beat with nonzero coordinates");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  a_run_only_hit: assert property (@(posedge clk) disable iff (rst)
    state == RUN |-> hit)
    else $error("digit loop running for an out-of-range index");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == RUN && cnt == '0 |=> state != RUN)
    else $error("digit loop ran past its last digit");

endmodule
